>>> rtl/tlbpt_pkg.sv
package tlbpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic en;
        logic hit;
    } t_tlb_upd;

endpackage

>>> rtl/tlbpt_ram.sv
module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tlbpt_tlb.sv
module tlbpt_tlb #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 8,
    localparam int IW = $clog2(ENTRIES),
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PAGE_W-1:0]   i_look_page,
    output logic                o_hit,
    output logic [IW-1:0]       o_hit_idx,
    output logic [FRAME_W-1:0]  o_hit_frame,
    input  tlbpt_pkg::t_tlb_upd i_upd,
    input  logic [IW-1:0]       i_upd_idx,
    input  logic [PAGE_W-1:0]   i_upd_page,
    input  logic [FRAME_W-1:0]  i_upd_frame
);

    logic [PAGE_W-1:0]  c_tag   [ENTRIES];
    logic [FRAME_W-1:0] c_frame [ENTRIES];
    logic [CW-1:0]      r_fill;
    logic               full;
    logic               do_shift;
    logic [IW-1:0]      pos;
    logic [CW-1:0]      last;

    // Entry zero is the oldest; entries at or above the fill count are empty.
    always_comb begin
        o_hit       = 1'b0;
        o_hit_idx   = '0;
        o_hit_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (CW'(i) < r_fill && c_tag[i] == i_look_page) begin
                o_hit       = 1'b1;
                o_hit_idx   = IW'(i);
                o_hit_frame = c_frame[i];
            end
        end
    end

    assign full     = (r_fill == CW'(ENTRIES));
    assign do_shift = i_upd.hit || full;
    assign pos      = i_upd.hit ? i_upd_idx : '0;
    assign last     = do_shift ? r_fill - CW'(1) : r_fill;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [PAGE_W-1:0]  r_tag;
        logic [FRAME_W-1:0] r_frm;
        logic [PAGE_W-1:0]  n_tag;
        logic [FRAME_W-1:0] n_frm;
        logic [PAGE_W-1:0]  src_tag;
        logic [FRAME_W-1:0] src_frm;

        if (g < ENTRIES - 1) begin : g_src
            assign src_tag = c_tag[g+1];
            assign src_frm = c_frame[g+1];
        end else begin : g_top
            assign src_tag = r_tag;
            assign src_frm = r_frm;
        end

        always_comb begin
            n_tag = r_tag;
            n_frm = r_frm;
            if (CW'(g) == last) begin
                n_tag = i_upd_page;
                n_frm = i_upd_frame;
            end else if (do_shift && IW'(g) >= pos && CW'(g) < last) begin
                n_tag = src_tag;
                n_frm = src_frm;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_upd.en) begin
                r_tag <= n_tag;
                r_frm <= n_frm;
            end
        end

        assign c_tag[g]   = r_tag;
        assign c_frame[g] = r_frm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_upd.en && !do_shift) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(ENTRIES))
        else $error("TLB fill count exceeds the number of entries.");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> CW'(o_hit_idx) < r_fill)
        else $error("TLB hit reported on an empty entry.");

    a_fill_grows_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.en && !i_upd.hit && !full) |=> r_fill == $past(r_fill) + CW'(1))
        else $error("TLB fill count did not grow on an append.");

endmodule

>>> rtl/tlb_page_table_translator_top.sv
// Translates one 16-bit virtual address per item through a fully associative TLB kept in
// recency order, falling back to a page table held in a synchronous RAM and
// allocating frames in order on a page fault. After reset the block clears the page table
// and accepts no item while it does so. An item is taken in with the TLB compare and the
// page-table read; the table write-back, the TLB update and the result register follow in a
// second step, which waits while a finished item is still held at the output and stalled. No
// new item is taken until the item is done. PAGE_COUNT must be a power of two. The hit and fault
// totals saturate at 65535.
module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0]   i_virtual_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0]   o_physical_address,
    output logic                           o_tlb_hit,
    output logic                           o_page_fault,
    output logic                           o_frames_exhausted,
    output logic [tlbpt_pkg::COUNT_W-1:0]  o_hit_total,
    output logic [tlbpt_pkg::COUNT_W-1:0]  o_fault_total
);

    localparam int PGW = $clog2(PAGE_COUNT);
    localparam int FW  = PGW;
    localparam int NFW = PGW + 1;
    localparam int IW  = $clog2(TLB_ENTRIES);
    localparam int AW  = tlbpt_pkg::ADDR_W;
    localparam int KW  = tlbpt_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state            r_state;
    logic [PGW-1:0]    r_clr_addr;
    logic [PGW-1:0]    r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [FW-1:0]     r_hit_frame;
    logic [NFW-1:0]    r_next_free;
    logic [KW-1:0]     r_hit_cnt;
    logic [KW-1:0]     r_fault_cnt;
    logic              r_out_valid;
    logic [AW-1:0]     r_paddr;
    logic              r_out_hit;
    logic              r_out_fault;
    logic              r_out_exh;

    logic [31:0]       va_shift;
    logic [PGW-1:0]    in_page;
    logic              accept;
    logic              commit;
    logic              look_hit;
    logic [IW-1:0]     look_idx;
    logic [FW-1:0]     look_frame;
    logic [FW:0]       rd_data;
    logic              present;
    logic              fault;
    logic              exhausted;
    logic [FW-1:0]     frame;
    logic [31:0]       paddr_wide;
    logic              ram_we;
    logic [PGW-1:0]    ram_waddr;
    logic [FW:0]       ram_wdata;
    logic [PGW-1:0]    ram_raddr;
    logic [KW-1:0]     n_hit_cnt;
    logic [KW-1:0]     n_fault_cnt;
    tlbpt_pkg::t_tlb_upd tlb_upd;

    assign va_shift = 32'(i_virtual_address) >> OFFSET_BITS;
    assign in_page  = va_shift[PGW-1:0];
    assign o_in_stall = (r_state != S_IDLE);
    assign accept   = i_in_valid && !o_in_stall;
    assign commit   = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);

    assign present    = rd_data[FW];
    assign exhausted  = !r_hit && !present && (r_next_free == NFW'(PAGE_COUNT));
    assign fault      = !r_hit && !present && !exhausted;
    assign frame      = r_hit ? r_hit_frame : (present ? rd_data[FW-1:0] : r_next_free[FW-1:0]);
    assign paddr_wide = (32'(frame) << OFFSET_BITS) | 32'(r_offset);

    assign n_hit_cnt   = (r_hit && r_hit_cnt != tlbpt_pkg::COUNT_MAX) ?
                         r_hit_cnt + KW'(1) : r_hit_cnt;
    assign n_fault_cnt = (fault && r_fault_cnt != tlbpt_pkg::COUNT_MAX) ?
                         r_fault_cnt + KW'(1) : r_fault_cnt;

    assign ram_we    = (r_state == S_CLEAR) || (commit && fault);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_page;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, r_next_free[FW-1:0]};
    assign ram_raddr = (r_state == S_IDLE) ? in_page : r_page;

    assign tlb_upd.en  = commit && !exhausted;
    assign tlb_upd.hit = r_hit;

    tlbpt_ram #(
        .WIDTH (FW + 1),
        .DEPTH (PAGE_COUNT)
    ) u_page_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    tlbpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PGW),
        .FRAME_W (FW)
    ) u_tlb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_look_page (in_page),
        .o_hit       (look_hit),
        .o_hit_idx   (look_idx),
        .o_hit_frame (look_frame),
        .i_upd       (tlb_upd),
        .i_upd_idx   (r_hit_idx),
        .i_upd_page  (r_page),
        .i_upd_frame (frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + PGW'(1);
                    if (r_clr_addr == PGW'(PAGE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (commit) begin
                        r_state     <= S_IDLE;
                        r_hit_cnt   <= n_hit_cnt;
                        r_fault_cnt <= n_fault_cnt;
                        r_paddr     <= exhausted ? '0 : paddr_wide[AW-1:0];
                        r_out_hit   <= r_hit;
                        r_out_fault <= fault;
                        r_out_exh   <= exhausted;
                        if (fault) begin
                            r_next_free <= r_next_free + NFW'(1);
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page      <= in_page;
            r_offset    <= i_virtual_address[OFFSET_BITS-1:0];
            r_hit       <= look_hit;
            r_hit_idx   <= look_idx;
            r_hit_frame <= look_frame;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_paddr;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_frames_exhausted = r_out_exh;
    assign o_hit_total        = r_hit_cnt;
    assign o_fault_total      = r_fault_cnt;

    a_commit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid && r_state == S_IDLE)
        else $error("A finished item did not reach the output register.");

    a_fault_allocates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && fault) |=> r_next_free == $past(r_next_free) + NFW'(1))
        else $error("A page fault did not advance the free frame pointer.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_out_hit, r_out_fault, r_out_exh}) <= 1)
        else $error("More than one outcome flag is set on an item.");

    a_hit_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_hit_cnt >= $past(r_hit_cnt))
        else $error("The hit total decreased.");

endmodule

>>> bench/tlb_page_table_translator_top_test.sv
module tlb_page_table_translator_top_test;

    localparam int TLB_N    = 16;
    localparam int PAGES    = 256;

    typedef struct packed {
        logic [tlbpt_pkg::ADDR_W-1:0]  paddr;
        logic                          hit;
        logic                          fault;
        logic                          exhausted;
        logic [tlbpt_pkg::COUNT_W-1:0] hit_total;
        logic [tlbpt_pkg::COUNT_W-1:0] fault_total;
    } t_xlat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [tlbpt_pkg::ADDR_W-1:0]  i_virtual_address = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [tlbpt_pkg::ADDR_W-1:0]  o_physical_address;
    logic                          o_tlb_hit;
    logic                          o_page_fault;
    logic                          o_frames_exhausted;
    logic [tlbpt_pkg::COUNT_W-1:0] o_hit_total;
    logic [tlbpt_pkg::COUNT_W-1:0] o_fault_total;

    tlb_page_table_translator_top #(
        .TLB_ENTRIES(TLB_N),
        .PAGE_COUNT (PAGES),
        .OFFSET_BITS(8)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_virtual_address (i_virtual_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_physical_address(o_physical_address),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault),
        .o_frames_exhausted(o_frames_exhausted),
        .o_hit_total       (o_hit_total),
        .o_fault_total     (o_fault_total)
    );

    always #5 i_clk = ~i_clk;

    bit [7:0]                    tlb_tag [TLB_N];
    bit [7:0]                    tlb_frm [TLB_N];
    bit                          tlb_vld [TLB_N];
    int                          tlb_fill = 0;
    bit                          pg_present [PAGES];
    bit [7:0]                    pg_frame [PAGES];
    bit [8:0]                    next_frame = '0;
    bit [tlbpt_pkg::COUNT_W-1:0] hit_cnt = '0;
    bit [tlbpt_pkg::COUNT_W-1:0] fault_cnt = '0;

    logic [tlbpt_pkg::ADDR_W-1:0] addr_q[$];
    t_xlat             xlat_q[$];
    int                queued_cnt = 0;
    int                accepted_cnt = 0;
    int                err_cnt = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    bit [7:0]          hot_pg [24];

    function automatic void tlb_drop(input int pos);
        for (int i = pos; i + 1 < tlb_fill; i++) begin
            tlb_tag[i] = tlb_tag[i+1];
            tlb_frm[i] = tlb_frm[i+1];
            tlb_vld[i] = tlb_vld[i+1];
        end
        if (tlb_fill > 0) begin
            tlb_fill--;
            tlb_vld[tlb_fill] = 1'b0;
        end
    endfunction

    function automatic void tlb_push(input bit [7:0] pg, input bit [7:0] frm);
        if (tlb_fill >= TLB_N) begin
            tlb_drop(0);
        end
        tlb_tag[tlb_fill] = pg;
        tlb_frm[tlb_fill] = frm;
        tlb_vld[tlb_fill] = 1'b1;
        tlb_fill++;
    endfunction

    function automatic t_xlat predict_xlat(input logic [tlbpt_pkg::ADDR_W-1:0] va);
        t_xlat    r;
        bit [7:0] pg;
        bit [7:0] frm;
        int       pos;
        r   = '0;
        pg  = va[15:8];
        frm = '0;
        pos = -1;
        for (int i = 0; i < tlb_fill; i++) begin
            if (tlb_vld[i] && tlb_tag[i] == pg) begin
                pos = i;
                break;
            end
        end
        if (pos >= 0) begin
            r.hit = 1'b1;
            frm   = tlb_frm[pos];
            if (hit_cnt != tlbpt_pkg::COUNT_MAX) begin
                hit_cnt++;
            end
            tlb_drop(pos);
            tlb_push(pg, frm);
        end else if (pg_present[pg]) begin
            frm = pg_frame[pg];
            tlb_push(pg, frm);
        end else if (next_frame < 9'(PAGES)) begin
            r.fault        = 1'b1;
            frm            = next_frame[7:0];
            next_frame++;
            pg_present[pg] = 1'b1;
            pg_frame[pg]   = frm;
            if (fault_cnt != tlbpt_pkg::COUNT_MAX) begin
                fault_cnt++;
            end
            tlb_push(pg, frm);
        end else begin
            r.exhausted = 1'b1;
        end
        if (!r.exhausted) begin
            r.paddr = {frm, va[7:0]};
        end
        r.hit_total   = hit_cnt;
        r.fault_total = fault_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [tlbpt_pkg::ADDR_W-1:0] rand_va();
        bit [7:0] pg;
        int       r;
        r = $urandom_range(99);
        if (r < 60) begin
            pg = hot_pg[5'($urandom_range(23))];
        end else if (r < 80) begin
            pg = hot_pg[5'($urandom_range(7))];
        end else begin
            pg = 8'($urandom_range(255));
        end
        return {pg, 8'($urandom_range(255))};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                xlat_q.push_back(predict_xlat(i_virtual_address));
                accepted_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (addr_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid        <= 1'b1;
                    i_virtual_address <= addr_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_xlat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (xlat_q.size() == 0) begin
                    $error("Result with no item pending: physical_address 0x%0h",
                           o_physical_address);
                    err_cnt++;
                end else begin
                    want = xlat_q.pop_front();
                    check_field("physical_address", 32'(want.paddr),
                                32'(o_physical_address));
                    check_field("tlb_hit", 32'(want.hit), 32'(o_tlb_hit));
                    check_field("page_fault", 32'(want.fault), 32'(o_page_fault));
                    check_field("frames_exhausted", 32'(want.exhausted),
                                32'(o_frames_exhausted));
                    check_field("hit_total", 32'(want.hit_total), 32'(o_hit_total));
                    check_field("fault_total", 32'(want.fault_total), 32'(o_fault_total));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_va(input logic [tlbpt_pkg::ADDR_W-1:0] va);
        addr_q.push_back(va);
        queued_cnt++;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (accepted_cnt != queued_cnt || xlat_q.size() != 0);
    endtask

    initial begin
        int send_mix [4];
        int recv_mix [4];
        int directed_cnt;
        send_mix = '{0, 81, 0, 30};
        recv_mix = '{0, 0, 81, 30};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Page 0 must miss on an empty TLB, both extreme pages are used, then the TLB is
        // filled, overflowed, and an evicted page and a middle entry are revisited.
        queue_va(16'h0000);
        queue_va(16'h00FF);
        queue_va(16'hFFFF);
        queue_va(16'hFF00);
        queue_va(16'h8000);
        queue_va(16'h7F55);
        for (int p = 1; p <= 12; p++) begin
            queue_va({8'(p), 8'hAA});
        end
        queue_va(16'h0D5A);
        queue_va(16'h0012);
        queue_va(16'h0533);
        queue_va(16'h0534);
        queue_va(16'hC8FF);
        queue_va(16'h0001);
        queue_va(16'hFF7E);
        directed_cnt = queued_cnt;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            foreach (hot_pg[k]) begin
                hot_pg[k] = 8'($urandom_range(255));
            end
            repeat (250) begin
                queue_va(rand_va());
            end
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (xlat_q.size() != 0) begin
            $error("%0d results never arrived", xlat_q.size());
            err_cnt++;
        end

        $display("Translated %0d addresses: %0d directed, 1000 random over four idling mixes.",
                 accepted_cnt, directed_cnt);
        $display("Final hit total %0d, fault total %0d, %0d mismatches.",
                 hit_cnt, fault_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
